// ===== src/g2pd_pkg.sv =====
// Shared types and constants for the G2 packet deframer.
// Used by every module of the block; depends on nothing.
package g2pd_pkg;

   localparam int BYTE_W    = 8;
   localparam int LEN_W     = 24;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int RSP_DATA_W = 32;
   localparam int RSP_USER_W = 5;

   localparam logic [LEN_W-1:0] MAX_PAYLOAD_RESET = 24'h010000;

   localparam logic [BYTE_W-1:0] CTRL_LEN_MASK  = 8'hC0;
   localparam logic [BYTE_W-1:0] CTRL_NAME_MASK = 8'h38;
   localparam logic [BYTE_W-1:0] CTRL_FLAG_MASK = 8'h07;
   localparam int CTRL_LEN_LSB  = 6;
   localparam int CTRL_NAME_LSB = 3;
   localparam int FLAG_BIG_ENDIAN_BIT = 1;

   localparam logic [0:0] REG_MAX_PAYLOAD = 1'b0;

   typedef enum logic [2:0] {
      PH_IDLE    = 3'd0,
      PH_LEN     = 3'd1,
      PH_NAME    = 3'd2,
      PH_PAYLOAD = 3'd3,
      PH_ERROR   = 3'd4
   } phase_type;

   typedef enum logic [2:0] {
      ROLE_PAD     = 3'd0,
      ROLE_CTRL    = 3'd1,
      ROLE_LEN     = 3'd2,
      ROLE_NAME    = 3'd3,
      ROLE_PAYLOAD = 3'd4,
      ROLE_DISCARD = 3'd5
   } role_type;

   typedef struct packed {
      phase_type        phase;
      logic [1:0]       len_left;
      logic [1:0]       len_index;
      logic [3:0]       name_left;
      logic [LEN_W-1:0] len_acc;
      logic [LEN_W-1:0] payload_left;
      logic             big_endian;
      logic             error;
   } state_type;

   typedef struct packed {
      logic [BYTE_W-1:0] byte_value;
      role_type          byte_role;
      logic              packet_end;
      logic [LEN_W-1:0]  payload_length;
      logic              big_endian;
      logic              frame_error;
   } result_type;

   typedef struct packed {
      phase_type phase;
      logic      error;
   } status_type;

endpackage

// ===== src/g2pd_csr.sv =====
// APB-style register port holding the maximum payload length.
// Depends on g2pd_pkg.
module g2pd_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [g2pd_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [g2pd_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [g2pd_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready,
   output logic [g2pd_pkg::LEN_W-1:0]     max_len
);
   import g2pd_pkg::*;

   logic [LEN_W-1:0] max_len_ff;
   logic [LEN_W-1:0] max_len_in;
   logic             sel_max;

   assign csr_pready = 1'b1;
   assign sel_max    = (csr_paddr[CSR_ADDR_W-1:CSR_ADDR_W-1] == REG_MAX_PAYLOAD);

   always_comb begin
      max_len_in = max_len_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready && sel_max) begin
         max_len_in = csr_pwdata[LEN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= MAX_PAYLOAD_RESET;
      end else begin
         max_len_ff <= max_len_in;
      end
   end

   assign csr_prdata = sel_max ? {{(CSR_DATA_W-LEN_W){1'b0}}, max_len_ff} : '0;
   assign max_len    = max_len_ff;

endmodule

// ===== src/g2pd_framer.sv =====
// Framing state and per-byte next-state logic of the deframer.
// Depends on g2pd_pkg.
module g2pd_framer (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       advance,
   input  logic [g2pd_pkg::BYTE_W-1:0] data_byte,
   input  logic [g2pd_pkg::LEN_W-1:0]  max_len,
   output g2pd_pkg::result_type       result,
   output g2pd_pkg::status_type       status
);
   import g2pd_pkg::*;

   state_type        st_ff;
   state_type        st_in;
   state_type        nxt;
   role_type         role;
   logic             pkt_end;
   logic [1:0]       len_left_dec;
   logic [3:0]       name_left_dec;
   logic [LEN_W-1:0] payload_dec;
   logic [1:0]       ctrl_len_size;
   logic [3:0]       ctrl_name_size;

   assign len_left_dec   = st_ff.len_left - 2'd1;
   assign name_left_dec  = st_ff.name_left - 4'd1;
   assign payload_dec    = st_ff.payload_left - 24'd1;
   assign ctrl_len_size  = 2'((data_byte & CTRL_LEN_MASK) >> CTRL_LEN_LSB);
   assign ctrl_name_size = 4'((data_byte & CTRL_NAME_MASK) >> CTRL_NAME_LSB) + 4'd1;

   always_comb begin
      nxt     = st_ff;
      role    = ROLE_PAD;
      pkt_end = 1'b0;
      case (st_ff.phase)
         PH_LEN: begin
            role = ROLE_LEN;
            if (st_ff.big_endian) begin
               nxt.len_acc = {st_ff.len_acc[LEN_W-BYTE_W-1:0], data_byte};
            end else begin
               case (st_ff.len_index)
                  2'd0:    nxt.len_acc = st_ff.len_acc | {16'd0, data_byte};
                  2'd1:    nxt.len_acc = st_ff.len_acc | {8'd0, data_byte, 8'd0};
                  2'd2:    nxt.len_acc = st_ff.len_acc | {data_byte, 16'd0};
                  default: nxt.len_acc = st_ff.len_acc;
               endcase
            end
            nxt.len_index = st_ff.len_index + 2'd1;
            nxt.len_left  = len_left_dec;
            if (len_left_dec == 2'd0) begin
               nxt.phase = PH_NAME;
            end
         end
         PH_NAME: begin
            role          = ROLE_NAME;
            nxt.name_left = name_left_dec;
            if (name_left_dec == 4'd0) begin
               if (st_ff.len_acc >= max_len) begin
                  nxt.error = 1'b1;
                  nxt.phase = PH_ERROR;
               end else if (st_ff.len_acc == '0) begin
                  pkt_end   = 1'b1;
                  nxt.phase = PH_IDLE;
               end else begin
                  nxt.payload_left = st_ff.len_acc;
                  nxt.phase        = PH_PAYLOAD;
               end
            end
         end
         PH_PAYLOAD: begin
            role             = ROLE_PAYLOAD;
            nxt.payload_left = payload_dec;
            if (payload_dec == '0) begin
               pkt_end   = 1'b1;
               nxt.phase = PH_IDLE;
            end
         end
         PH_ERROR: begin
            role = ROLE_DISCARD;
         end
         default: begin
            nxt.phase = PH_IDLE;
            if (data_byte != '0) begin
               role           = ROLE_CTRL;
               nxt.name_left  = ctrl_name_size;
               nxt.big_endian = data_byte[FLAG_BIG_ENDIAN_BIT];
               nxt.len_acc    = '0;
               nxt.len_index  = 2'd0;
               nxt.len_left   = ctrl_len_size;
               nxt.phase      = (ctrl_len_size != 2'd0) ? PH_LEN : PH_NAME;
            end
         end
      endcase
   end

   assign st_in = advance ? nxt : st_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= '0;
      end else begin
         st_ff <= st_in;
      end
   end

   assign result.byte_value     = data_byte;
   assign result.byte_role      = role;
   assign result.packet_end     = pkt_end;
   assign result.payload_length = nxt.len_acc;
   assign result.big_endian     = nxt.big_endian;
   assign result.frame_error    = nxt.error;

   assign status.phase = st_ff.phase;
   assign status.error = st_ff.error;

endmodule

// ===== src/g2pd_out_reg.sv =====
// Result register of the deframer with its valid/ready hold logic.
// Depends on g2pd_pkg.
module g2pd_out_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  g2pd_pkg::result_type result_in,
   input  logic                 out_ready,
   output logic                 out_valid,
   output g2pd_pkg::result_type result_out
);
   import g2pd_pkg::*;

   logic       valid_ff;
   logic       valid_in;
   result_type data_ff;

   assign valid_in = load || (valid_ff && !out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result_in;
      end
   end

   assign out_valid  = valid_ff;
   assign result_out = data_ff;

endmodule

// ===== src/g2pd_top.sv =====
// Top level of the G2 packet deframer: input byte register, framer, result register.
// Depends on g2pd_pkg, g2pd_csr, g2pd_framer and g2pd_out_reg.
//
// Usage:
//   req_* carries one received stream byte per beat. rsp_* returns one tagged
//   beat per input byte: the byte, its role in the packet, packet end on
//   rsp_tlast, the payload length so far, the length byte order and the
//   sticky frame error. csr_* sets the maximum payload length (address 0).
//   An input beat passes through the input register and then the result
//   register to become its result beat. One byte is taken per cycle while
//   the receiver does not stall, set by the single framing state update
//   per byte. Reset clears the framing state and the error flag and loads
//   the limit with 65536. When the receiver stalls, the result register holds
//   its beat and the input register holds the next byte; req_tready drops
//   only when both are full and rsp_tready is low.
module g2_packet_deframer_unit (
   input  logic                             clock,
   input  logic                             reset,
   // req_tdata: data_byte[7:0]
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [g2pd_pkg::BYTE_W-1:0]      req_tdata,
   // rsp_tdata: byte_value[7:0], payload_length[31:8]
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [g2pd_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                             rsp_tlast,
   // rsp_tuser: byte_role[2:0], big_endian[3], frame_error[4]
   output logic [g2pd_pkg::RSP_USER_W-1:0]  rsp_tuser,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [g2pd_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [g2pd_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [g2pd_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready
);
   import g2pd_pkg::*;

   logic              in_valid_ff;
   logic              in_valid_in;
   logic [BYTE_W-1:0] in_byte_ff;
   logic              req_accept;
   logic              advance;
   logic [LEN_W-1:0]  max_len;
   result_type        step_result;
   result_type        rsp_result;
   status_type        status;

   assign advance     = in_valid_ff && (!rsp_tvalid || rsp_tready);
   assign req_tready  = !in_valid_ff || advance;
   assign req_accept  = req_tvalid && req_tready;
   assign in_valid_in = req_accept || (in_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_byte_ff <= req_tdata;
      end
   end

   g2pd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .max_len     (max_len)
   );

   g2pd_framer u_framer (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .data_byte (in_byte_ff),
      .max_len   (max_len),
      .result    (step_result),
      .status    (status)
   );

   g2pd_out_reg u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (advance),
      .result_in  (step_result),
      .out_ready  (rsp_tready),
      .out_valid  (rsp_tvalid),
      .result_out (rsp_result)
   );

   assign rsp_tdata = {rsp_result.payload_length, rsp_result.byte_value};
   assign rsp_tlast = rsp_result.packet_end;
   assign rsp_tuser = {rsp_result.frame_error, rsp_result.big_endian, rsp_result.byte_role};

   a_error_sticky: assert property (@(posedge clock) disable iff (reset)
      !$fell(status.error))
      else $error("frame error flag cleared without reset");

   a_error_phase: assert property (@(posedge clock) disable iff (reset)
      status.error == (status.phase == PH_ERROR))
      else $error("error flag and error phase disagree");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      !(advance && rsp_tvalid && !rsp_tready))
      else $error("stalled result beat overwritten");

   a_discard_flagged: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_result.byte_role == ROLE_DISCARD) |-> rsp_result.frame_error)
      else $error("discarded beat without frame error");

endmodule
